// File: hdl/rmm_pkg.sv
// Shared widths, limits, status codes and divider status type for the running statistics core.
package rmm_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned ValW    = 31;
  localparam int unsigned SumW    = 47;
  localparam int unsigned CountW  = 16;
  localparam int unsigned FracW   = 8;
  localparam int unsigned MeanW   = 39;
  localparam int unsigned DivndW  = SumW + FracW;
  localparam int unsigned StepW   = $clog2(MeanW + 1);

  localparam longint unsigned CountLimit = 65535;
  localparam logic [CountW-1:0] CountCap =
      (CountLimit > 64'd65535) ? {CountW{1'b1}} : CountW'(CountLimit);

  typedef enum logic [1:0] {
    StsAccept = 2'd0,
    StsReject = 2'd1,
    StsEnded  = 2'd2,
    StsFull   = 2'd3
  } status_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hdl/rmm_div.sv
// Bit-serial restoring divider: (sum << 8) / count, one quotient bit per cycle.
module rmm_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [rmm_pkg::DivndW-1:0]       dividend_i,
  input  logic [rmm_pkg::CountW-1:0]       divisor_i,
  output rmm_pkg::div_stat_t               stat_o,
  output logic [rmm_pkg::MeanW-1:0]        quotient_o
);

  logic [rmm_pkg::CountW-1:0] rem_q, rem_d;
  logic [rmm_pkg::MeanW-1:0]  quo_q, quo_d;
  logic [rmm_pkg::CountW-1:0] dvs_q, dvs_d;
  logic [rmm_pkg::StepW-1:0]  cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [rmm_pkg::CountW:0]   trial;
  logic [rmm_pkg::CountW:0]   diff;
  logic                       ge;

  // Quotient fits in MeanW bits, so the top dividend bits are already below the divisor.
  assign trial = {rem_q, quo_q[rmm_pkg::MeanW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i[rmm_pkg::DivndW-1:rmm_pkg::MeanW];
      quo_d  = dividend_i[rmm_pkg::MeanW-1:0];
      dvs_d  = divisor_i;
      cnt_d  = rmm_pkg::StepW'(rmm_pkg::MeanW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[rmm_pkg::CountW-1:0] : trial[rmm_pkg::CountW-1:0];
      quo_d = {quo_q[rmm_pkg::MeanW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == rmm_pkg::StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

// File: hdl/running_min_max_mean_core.sv
// Top level: running min, max, count and fixed-point mean over positive samples.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+-----------------------------------------------
//   in      | in_valid_i | in_stall_o  | sample_i
//   out     | out_valid_o| out_stall_i | status_o largest_o smallest_o sample_count_o mean_o
//
// An accepted sample starts the bit-serial divider that recomputes the mean,
// one quotient bit per cycle.
// A rejected, ended or full item runs no division.
// The input stalls from acceptance until the result is loaded into the output register.
// A new item is taken while the previous result still waits in the output register.
// Reset clears all statistics and reopens the session.
module running_min_max_mean_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rmm_pkg::SampleW-1:0]       sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic [rmm_pkg::ValW-1:0]          largest_o,
  output logic [rmm_pkg::ValW-1:0]          smallest_o,
  output logic [rmm_pkg::CountW-1:0]        sample_count_o,
  output logic [rmm_pkg::MeanW-1:0]         mean_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StOut  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  rmm_pkg::status_e res_q, res_d;

  logic [rmm_pkg::ValW-1:0]   max_q, max_d;
  logic [rmm_pkg::ValW-1:0]   min_q, min_d;
  logic [rmm_pkg::SumW-1:0]   sum_q, sum_d;
  logic [rmm_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [rmm_pkg::MeanW-1:0]  mean_q, mean_d;
  logic                       over_q, over_d;

  logic                       out_valid_q, out_valid_d;
  logic [1:0]                 out_status_q;
  logic [rmm_pkg::ValW-1:0]   out_max_q, out_min_q;
  logic [rmm_pkg::CountW-1:0] out_cnt_q;
  logic [rmm_pkg::MeanW-1:0]  out_mean_q;

  logic                       in_acc;
  logic                       load_out;
  logic                       div_start;
  logic [rmm_pkg::ValW-1:0]   val;
  rmm_pkg::div_stat_t         div_stat;
  logic [rmm_pkg::MeanW-1:0]  quotient;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && (state_q == StIdle);
  assign val        = sample_i[rmm_pkg::ValW-1:0];
  assign load_out   = (state_q == StOut) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    max_d     = max_q;
    min_d     = min_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    mean_d    = mean_q;
    over_d    = over_q;
    div_start = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StOut;
          if (over_q) begin
            res_d = rmm_pkg::StsEnded;
          end else if (sample_i == {rmm_pkg::SampleW{1'b1}}) begin
            over_d = 1'b1;
            res_d  = rmm_pkg::StsEnded;
          end else if (sample_i[rmm_pkg::SampleW-1] || (sample_i == '0)) begin
            res_d = rmm_pkg::StsReject;
          end else if (cnt_q >= rmm_pkg::CountCap) begin
            res_d = rmm_pkg::StsFull;
          end else begin
            res_d = rmm_pkg::StsAccept;
            if (cnt_q == '0) begin
              max_d = val;
              min_d = val;
            end else begin
              if (val > max_q) max_d = val;
              if (val < min_q) min_d = val;
            end
            sum_d     = sum_q + rmm_pkg::SumW'(val);
            cnt_d     = cnt_q + 1'b1;
            div_start = 1'b1;
            state_d   = StDiv;
          end
        end
      end
      StDiv: begin
        if (div_stat.done) begin
          mean_d  = quotient;
          state_d = StOut;
        end
      end
      StOut: begin
        if (load_out) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  rmm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_d, {rmm_pkg::FracW{1'b0}}}),
    .divisor_i  (cnt_d),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_q       <= rmm_pkg::StsAccept;
      max_q       <= '0;
      min_q       <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      mean_q      <= '0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      max_q       <= max_d;
      min_q       <= min_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      mean_q      <= mean_d;
      over_q      <= over_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Snapshot the statistics into the output register.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= res_q;
      out_max_q    <= max_q;
      out_min_q    <= min_q;
      out_cnt_q    <= cnt_q;
      out_mean_q   <= mean_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign largest_o      = out_max_q;
  assign smallest_o     = out_min_q;
  assign sample_count_o = out_cnt_q;
  assign mean_o         = out_mean_q;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rmm_pkg::CountCap)
    else $error("sample count above its limit");

  a_closed_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    over_q |=> over_q && $stable(cnt_q) && $stable(sum_q))
    else $error("statistics changed after session end");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == StDiv))
    else $error("divider finished outside the divide state");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (min_q <= max_q))
    else $error("minimum above maximum");

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == StDiv))
    else $error("divider running outside the divide state");

endmodule

// File: sim/running_min_max_mean_core_tb.sv
// Self-checking testbench for running_min_max_mean_core with a predicting scoreboard.
`timescale 1ns / 1ps

module running_min_max_mean_core_tb;

  typedef struct packed {
    rmm_pkg::status_e                status;
    logic [rmm_pkg::ValW-1:0]        largest;
    logic [rmm_pkg::ValW-1:0]        smallest;
    logic [rmm_pkg::CountW-1:0]      count;
    logic [rmm_pkg::MeanW-1:0]       mean;
  } stats_report_t;

  class running_stats_scoreboard;
    logic [rmm_pkg::ValW-1:0]   max_val;
    logic [rmm_pkg::ValW-1:0]   min_val;
    logic [rmm_pkg::SumW-1:0]   sum;
    logic [rmm_pkg::CountW-1:0] count;
    bit                         closed;
    stats_report_t              expected_reports[$];
    int unsigned                mismatch_count;

    function new();
      max_val = '0;
      min_val = '0;
      sum = '0;
      count = '0;
      closed = 1'b0;
      mismatch_count = 0;
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    function stats_report_t predict_report(logic [rmm_pkg::SampleW-1:0] sample);
      stats_report_t                rep;
      logic [rmm_pkg::ValW-1:0]     v;
      logic [rmm_pkg::DivndW-1:0]   scaled;
      v = sample[rmm_pkg::ValW-1:0];
      if (closed) begin
        rep.status = rmm_pkg::StsEnded;
      end else if (sample == '1) begin
        closed = 1'b1;
        rep.status = rmm_pkg::StsEnded;
      end else if (sample == '0 || sample[rmm_pkg::SampleW-1]) begin
        rep.status = rmm_pkg::StsReject;
      end else if (count >= rmm_pkg::CountCap) begin
        rep.status = rmm_pkg::StsFull;
      end else begin
        if (count == '0) begin
          min_val = v;
          max_val = v;
        end else begin
          if (v > max_val) max_val = v;
          if (v < min_val) min_val = v;
        end
        sum = sum + rmm_pkg::SumW'(v);
        count = count + 1'b1;
        rep.status = rmm_pkg::StsAccept;
      end
      rep.largest = max_val;
      rep.smallest = min_val;
      rep.count = count;
      if (count == '0) begin
        rep.mean = '0;
      end else begin
        scaled = {sum, {rmm_pkg::FracW{1'b0}}};
        rep.mean = rmm_pkg::MeanW'(scaled / rmm_pkg::DivndW'(count));
      end
      return rep;
    endfunction

    function void note_sample(logic [rmm_pkg::SampleW-1:0] sample);
      expected_reports.push_back(predict_report(sample));
    endfunction

    function void note_error(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
    endfunction

    function void check_report(stats_report_t got);
      stats_report_t want;
      if (expected_reports.size() == 0) begin
        note_error($sformatf("unexpected beat: st=%0d max=%0d min=%0d cnt=%0d mean=%0d",
                             got.status, got.largest, got.smallest, got.count, got.mean));
        return;
      end
      want = expected_reports.pop_front();
      if (got.status !== want.status || got.largest !== want.largest ||
          got.smallest !== want.smallest || got.count !== want.count ||
          got.mean !== want.mean) begin
        note_error($sformatf({"mismatch: exp st=%0d max=%0d min=%0d cnt=%0d mean=%0d",
                              " | got st=%0d max=%0d min=%0d cnt=%0d mean=%0d"},
                             want.status, want.largest, want.smallest, want.count, want.mean,
                             got.status, got.largest, got.smallest, got.count, got.mean));
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [rmm_pkg::SampleW-1:0]   sample_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [1:0]                    status_o;
  logic [rmm_pkg::ValW-1:0]      largest_o;
  logic [rmm_pkg::ValW-1:0]      smallest_o;
  logic [rmm_pkg::CountW-1:0]    sample_count_o;
  logic [rmm_pkg::MeanW-1:0]     mean_o;

  bit                      idle_on = 1'b1;
  running_stats_scoreboard stats = new();

  running_min_max_mean_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .largest_o      (largest_o),
    .smallest_o     (smallest_o),
    .sample_count_o (sample_count_o),
    .mean_o         (mean_o)
  );

  always #10 clk_i = ~clk_i;

  // Hold a sample until the core takes it, then predict its report.
  task automatic send_sample(input logic [rmm_pkg::SampleW-1:0] value);
    while (idle_on && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    stats.note_sample(value);
  endtask

  // Drop valid and wait for every outstanding report.
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (stats.pending() != 0);
  endtask

  function automatic logic [rmm_pkg::SampleW-1:0] random_sample();
    logic [rmm_pkg::SampleW-1:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0: begin
        r[rmm_pkg::SampleW-1] = 1'b1;
        if (r == '1) r = 32'h8000_0000;
        if ($urandom_range(3) == 0) r = '0;
      end
      1: r = $urandom_range(16, 1);
      2: r = 32'h7FFF_FFFF - $urandom_range(15, 0);
      default: begin
        r[rmm_pkg::SampleW-1] = 1'b0;
        if (r == '0) r = 1;
      end
    endcase
    return r;
  endfunction

  // Receive side: random stall, check every accepted beat.
  initial begin
    stats_report_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        got.status = rmm_pkg::status_e'(status_o);
        got.largest = largest_o;
        got.smallest = smallest_o;
        got.count = sample_count_o;
        got.mean = mean_o;
        stats.check_report(got);
      end
      out_stall_i <= idle_on && ($urandom_range(99) < 24);
    end
  end

  initial begin
    #(64'd400_000_000);
    $display("running_min_max_mean_core regression: fail");
    $finish;
  end

  initial begin
    logic [rmm_pkg::SampleW-1:0] directed_samples[$];
    logic [rmm_pkg::SampleW-1:0] v;
    directed_samples = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFE, 32'h7FFF_FFFF,
                         32'h0000_0001, 32'h7FFF_FFFF, 32'h5555_5555, 32'h2AAA_AAAA,
                         32'h8000_0001, 32'h4000_0000, 32'h0000_0002, 32'h0000_0100,
                         32'hAAAA_AAAA, 32'h7FFF_FFFE};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_samples[i]) send_sample(directed_samples[i]);

    for (int i = 0; i < 1300; i++) begin
      if (i == 400) idle_on = 1'b0;
      if (i == 700) idle_on = 1'b1;
      if (i == 1000 || $urandom_range(199) == 0) drain_reports();
      send_sample(random_sample());
    end

    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0000_0001);
    send_sample(32'h0000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h1234_5678);
    drain_reports();

    // Close the session; everything after answers ended.
    send_sample(32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) begin
      case (i % 4)
        0: v = 32'hFFFF_FFFF;
        1: v = '0;
        default: v = $urandom();
      endcase
      send_sample(v);
    end
    send_sample(32'h7FFF_FFFF);

    drain_reports();
    repeat (60) @(posedge clk_i);
    if (stats.mismatch_count == 0) begin
      $display("running_min_max_mean_core regression: pass");
    end else begin
      $display("running_min_max_mean_core regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/rmm_pkg.sv
hdl/rmm_div.sv
hdl/running_min_max_mean_core.sv
sim/running_min_max_mean_core_tb.sv
